>>> design/internet_checksum_pseudo_header_top_macros.svh
// ----------------------------------------------------------------------------
// Checksum engine assertion macros
// Shared concurrent assertion forms, clocked on aclk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef INTERNET_CHECKSUM_PSEUDO_HEADER_TOP_MACROS_SVH
`define INTERNET_CHECKSUM_PSEUDO_HEADER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define ICHK_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("checksum engine assertion failed");

// Consequent must hold in the cycle after the antecedent
`define ICHK_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("checksum engine assertion failed");

`endif

>>> design/ichk_pkg.sv
// ----------------------------------------------------------------------------
// Checksum engine package
// Shared constants, types and ones' complement helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package ichk_pkg;

    // Payload bytes carried by one chunk
    localparam int CHUNK_BYTES = 8;

    // Field widths
    localparam int FUNC_W     = 2;
    localparam int ADDR_W     = 64;
    localparam int PROTO_W    = 8;
    localparam int LEN_W      = 32;
    localparam int PAYLOAD_W  = 64;
    localparam int COUNT_W    = 4;
    localparam int WORD_W     = 16;

    // Stream data widths (input padded to whole bytes)
    localparam int S_FIELDS_W = 4 * ADDR_W + PROTO_W + LEN_W + PAYLOAD_W + COUNT_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = WORD_W;

    // Lanes: four 64-bit groups plus one group for length and protocol
    localparam int LANES       = 5;
    localparam int GROUP_W     = 64;
    localparam int GROUP_WORDS = GROUP_W / WORD_W;
    localparam int LANE_SUM_W  = WORD_W + $clog2(GROUP_WORDS);
    localparam int TOTAL_W     = WORD_W + $clog2(LANES * GROUP_WORDS);

    // Item kind carried on tuser
    typedef enum logic [FUNC_W-1:0] {
        FUNC_PAYLOAD = 2'd0,
        FUNC_IPV4    = 2'd1,
        FUNC_IPV6    = 2'd2,
        FUNC_NONE    = 2'd3
    } ichk_func_t;

    // Per-stage control carried alongside the data
    typedef struct packed {
        logic valid;
        logic last;
    } ichk_ctl_t;

    // Fold one end-around carry into a 16-bit word
    function automatic logic [WORD_W-1:0] oc_fold17(input logic [WORD_W:0] s);
        return s[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, s[WORD_W]};
    endfunction

endpackage

`default_nettype wire

>>> design/ichk_lane.sv
// ----------------------------------------------------------------------------
// Checksum lane
// Adds the four 16-bit words of one 64-bit group and registers the sum.
// ----------------------------------------------------------------------------
`default_nettype none

module ichk_lane (
    input  wire logic                            aclk,
    input  wire logic                            en,
    input  wire logic [ichk_pkg::GROUP_W-1:0]    group_in,
    output logic      [ichk_pkg::LANE_SUM_W-1:0] sum_out
);
    import ichk_pkg::*;

    logic [LANE_SUM_W-1:0] sum_next;
    logic [LANE_SUM_W-1:0] sum_reg;

    // Add the words of the group
    always_comb begin
        sum_next = '0;
        for (int k = 0; k < GROUP_WORDS; k++) begin
            sum_next = sum_next + LANE_SUM_W'(group_in[k*WORD_W +: WORD_W]);
        end
    end

    // Hold while the pipeline is stalled
    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg <= sum_next;
        end
    end

    assign sum_out = sum_reg;

endmodule

`default_nettype wire

>>> design/ichk_merge.sv
// ----------------------------------------------------------------------------
// Checksum lane merge
// Adds the lane sums and folds the total to one ones' complement word.
// ----------------------------------------------------------------------------
`default_nettype none

module ichk_merge (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            en,
    input  wire ichk_pkg::ichk_ctl_t             ctl_in,
    input  wire logic [ichk_pkg::LANE_SUM_W-1:0] lane_sum [ichk_pkg::LANES],
    output ichk_pkg::ichk_ctl_t                  ctl_out,
    output logic      [ichk_pkg::WORD_W-1:0]     word_out
);
    import ichk_pkg::*;

    logic [TOTAL_W-1:0] total;
    logic [WORD_W:0]    fold1;
    logic [WORD_W-1:0]  word_next;
    logic [WORD_W-1:0]  word_reg;
    ichk_ctl_t          ctl_reg;

    // Sum the lanes, then fold the high bits back twice
    always_comb begin
        total = '0;
        for (int l = 0; l < LANES; l++) begin
            total = total + TOTAL_W'(lane_sum[l]);
        end
        fold1 = {1'b0, total[WORD_W-1:0]}
              + (WORD_W+1)'(total[TOTAL_W-1:WORD_W]);
        word_next = oc_fold17(fold1);
    end

    // Control register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_in;
        end
    end

    // Item word register
    always_ff @(posedge aclk) begin
        if (en) begin
            word_reg <= word_next;
        end
    end

    assign ctl_out  = ctl_reg;
    assign word_out = word_reg;

endmodule

`default_nettype wire

>>> design/internet_checksum_pseudo_header_top.sv
// ----------------------------------------------------------------------------
// Internet checksum engine with pseudo-header support
// Running ones' complement checksum over payload and IPv4/IPv6 pseudo-headers.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one transaction per item. s_tuser selects payload chunk,
//   IPv4 pseudo-header or IPv6 pseudo-header; s_tlast ends the packet.
//   Master channel: one transaction per packet carrying the checksum,
//   produced only for items that carry s_tlast.
//   Throughput: one item per cycle unless stalled. Five lanes each add four
//   words, a merge stage folds the lane sums, and a single end-around adder
//   accumulates. Result path: the last item passes the lane register, the
//   merge register and the output register before m_tvalid rises.
//   Reset: clears the pipeline valid bits, the output valid and the running
//   sum; the first packet starts from zero.
//   Stall: while m_tvalid is high and m_tready low, the whole pipeline
//   holds and s_tready drops; payload already accepted is not lost.
// ----------------------------------------------------------------------------
`default_nettype none
`include "internet_checksum_pseudo_header_top_macros.svh"

module internet_checksum_pseudo_header_top (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // s_tdata: src_high, src_low, dst_high, dst_low, protocol, length,
    //          payload, byte_count, zero pad
    input  wire logic [ichk_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser: func
    input  wire logic [ichk_pkg::FUNC_W-1:0]    s_tuser,
    input  wire logic                           s_tlast,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // m_tdata: checksum
    output logic      [ichk_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready
);
    import ichk_pkg::*;

    logic [ADDR_W-1:0]    src_high;
    logic [ADDR_W-1:0]    src_low;
    logic [ADDR_W-1:0]    dst_high;
    logic [ADDR_W-1:0]    dst_low;
    logic [PROTO_W-1:0]   protocol;
    logic [LEN_W-1:0]     length;
    logic [PAYLOAD_W-1:0] payload;
    logic [COUNT_W-1:0]   byte_count;
    logic [COUNT_W-1:0]   eff_count;
    logic [PAYLOAD_W-1:0] kept;
    logic [WORD_W-1:0]    proto_word;

    logic [GROUP_W-1:0]    lane_grp [LANES];
    logic [LANE_SUM_W-1:0] lane_sum [LANES];

    logic               en;
    ichk_ctl_t          s1_ctl_reg;
    ichk_ctl_t          s2_ctl;
    logic [WORD_W-1:0]  s2_word;
    logic [WORD_W-1:0]  acc_reg;
    logic [WORD_W-1:0]  acc_sum;
    logic               m_tvalid_reg;
    logic [WORD_W-1:0]  m_tdata_reg;

    // Unpack the transaction
    assign src_high   = s_tdata[0*ADDR_W +: ADDR_W];
    assign src_low    = s_tdata[1*ADDR_W +: ADDR_W];
    assign dst_high   = s_tdata[2*ADDR_W +: ADDR_W];
    assign dst_low    = s_tdata[3*ADDR_W +: ADDR_W];
    assign protocol   = s_tdata[4*ADDR_W +: PROTO_W];
    assign length     = s_tdata[4*ADDR_W+PROTO_W +: LEN_W];
    assign payload    = s_tdata[4*ADDR_W+PROTO_W+LEN_W +: PAYLOAD_W];
    assign byte_count = s_tdata[4*ADDR_W+PROTO_W+LEN_W+PAYLOAD_W +: COUNT_W];
    assign proto_word = {{(WORD_W-PROTO_W){1'b0}}, protocol};

    // Advance the whole pipeline unless a result is waiting on the receiver
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // Keep only the valid payload bytes, first byte in the top bits
    always_comb begin
        eff_count = (byte_count > COUNT_W'(CHUNK_BYTES)) ? COUNT_W'(CHUNK_BYTES)
                                                         : byte_count;
        kept = '0;
        for (int i = 0; i < PAYLOAD_W / 8; i++) begin
            if (COUNT_W'(i) < eff_count) begin
                kept[PAYLOAD_W-8-8*i +: 8] = payload[PAYLOAD_W-8-8*i +: 8];
            end
        end
    end

    // Route the item's words onto the lanes
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            lane_grp[l] = '0;
        end
        unique case (ichk_func_t'(s_tuser))
            FUNC_PAYLOAD: begin
                lane_grp[0] = kept;
            end
            FUNC_IPV4: begin
                lane_grp[0] = {src_low[31:0], dst_low[31:0]};
                lane_grp[4] = {{WORD_W{1'b0}}, length[WORD_W-1:0], proto_word,
                               {WORD_W{1'b0}}};
            end
            FUNC_IPV6: begin
                lane_grp[0] = src_high;
                lane_grp[1] = src_low;
                lane_grp[2] = dst_high;
                lane_grp[3] = dst_low;
                lane_grp[4] = {length[LEN_W-1:WORD_W], length[WORD_W-1:0], proto_word,
                               {WORD_W{1'b0}}};
            end
            FUNC_NONE: begin
                lane_grp[0] = '0;
            end
            default: begin
                lane_grp[0] = '0;
            end
        endcase
    end

    // Lane stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_ctl_reg <= '0;
        end else if (en) begin
            s1_ctl_reg <= '{valid: s_tvalid, last: s_tlast};
        end
    end

    // Lanes
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        ichk_lane u_lane (
            .aclk     (aclk),
            .en       (en),
            .group_in (lane_grp[g]),
            .sum_out  (lane_sum[g])
        );
    end

    // Merge the lane sums
    ichk_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .ctl_in   (s1_ctl_reg),
        .lane_sum (lane_sum),
        .ctl_out  (s2_ctl),
        .word_out (s2_word)
    );

    // Accumulate with end-around carry
    assign acc_sum = oc_fold17({1'b0, acc_reg} + {1'b0, s2_word});

    // Running sum and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= s2_ctl.valid && s2_ctl.last;
            if (s2_ctl.valid) begin
                acc_reg <= s2_ctl.last ? '0 : acc_sum;
            end
        end
    end

    // Checksum payload
    always_ff @(posedge aclk) begin
        if (en && s2_ctl.valid && s2_ctl.last) begin
            m_tdata_reg <= ~acc_sum;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Assertions
    `ICHK_ASSERT_NEXT(a_sum_cleared_after_last, en && s2_ctl.valid && s2_ctl.last, acc_reg == '0)
    `ICHK_ASSERT_NEXT(a_result_after_last, en && s2_ctl.valid && s2_ctl.last, m_tvalid)
    `ICHK_ASSERT_NEXT(a_stall_holds_pipe, !en, $stable(s1_ctl_reg) && $stable(s2_ctl) && $stable(acc_reg))
    `ICHK_ASSERT_SAME(a_ready_while_idle, !m_tvalid, s_tready)

endmodule

`default_nettype wire

>>> tb/checksum_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Checksum engine stream checker
// Watches both stream channels, keeps its own running ones' complement sum
// from every accepted item, and compares each checksum transaction on the
// master side against the oldest predicted value, in order.
// ----------------------------------------------------------------------------
module checksum_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [ichk_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [ichk_pkg::FUNC_W-1:0]    s_tuser,
    input  logic                           s_tlast,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [ichk_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    output int                             fail_count,
    output int                             pending,
    output int                             items_seen,
    output int                             sums_seen
);
    import ichk_pkg::*;

    // s_tdata layout, highest member first
    typedef struct packed {
        logic [3:0]  pad;
        logic [3:0]  byte_count;
        logic [63:0] payload;
        logic [31:0] length;
        logic [7:0]  protocol;
        logic [63:0] dst_low;
        logic [63:0] dst_high;
        logic [63:0] src_low;
        logic [63:0] src_high;
    } item_fields_t;

    logic [15:0]  packet_sum;
    logic [15:0]  next_sum;
    logic [15:0]  want;
    logic [15:0]  expected_sums[$];
    item_fields_t fields;

    // Add one word with end-around carry
    function automatic logic [15:0] oc_add16(input logic [15:0] acc, input logic [15:0] w);
        logic [16:0] s;
        s = {1'b0, acc} + {1'b0, w};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    // Add four big-endian words of a 64-bit group
    function automatic logic [15:0] add_group(input logic [15:0] acc, input logic [63:0] v);
        for (int k = 0; k < 4; k++)
            acc = oc_add16(acc, v[63 - 16 * k -: 16]);
        return acc;
    endfunction

    // Fold one item into the running sum
    function automatic logic [15:0] fold_item(input logic [15:0] acc,
                                              input logic [FUNC_W-1:0] kind,
                                              input item_fields_t f);
        logic [63:0] kept;
        int          n;
        kept = '0;
        case (kind)
            FUNC_PAYLOAD: begin
                // zero the bytes past the valid count
                n = (f.byte_count > CHUNK_BYTES) ? CHUNK_BYTES : int'(f.byte_count);
                for (int i = 0; i < n; i++)
                    kept[63 - 8 * i -: 8] = f.payload[63 - 8 * i -: 8];
                acc = add_group(acc, kept);
            end
            FUNC_IPV4: begin
                acc = oc_add16(acc, f.src_low[31:16]);
                acc = oc_add16(acc, f.src_low[15:0]);
                acc = oc_add16(acc, f.dst_low[31:16]);
                acc = oc_add16(acc, f.dst_low[15:0]);
                acc = oc_add16(acc, {8'd0, f.protocol});
                acc = oc_add16(acc, f.length[15:0]);
            end
            FUNC_IPV6: begin
                acc = add_group(acc, f.src_high);
                acc = add_group(acc, f.src_low);
                acc = add_group(acc, f.dst_high);
                acc = add_group(acc, f.dst_low);
                acc = oc_add16(acc, f.length[31:16]);
                acc = oc_add16(acc, f.length[15:0]);
                acc = oc_add16(acc, {8'd0, f.protocol});
            end
            default: begin
                // unknown kind adds nothing
            end
        endcase
        return acc;
    endfunction

    initial begin
        fail_count = 0;
        pending    = 0;
        items_seen = 0;
        sums_seen  = 0;
        packet_sum = '0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            packet_sum = '0;
            expected_sums.delete();
        end else begin
            // compare a checksum transaction with the oldest prediction
            if (m_tvalid && m_tready) begin
                sums_seen++;
                if (expected_sums.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 20)
                        $display("%0t checksum with none expected: expected none actual %h",
                                 $time, m_tdata);
                end else begin
                    want = expected_sums.pop_front();
                    if (m_tdata !== want) begin
                        fail_count++;
                        if (fail_count <= 20)
                            $display("%0t checksum mismatch: expected %h actual %h",
                                     $time, want, m_tdata);
                    end
                end
            end
            // advance the predicted sum on each input transaction
            if (s_tvalid && s_tready) begin
                items_seen++;
                fields   = s_tdata;
                next_sum = fold_item(packet_sum, s_tuser, fields);
                if (s_tlast) begin
                    expected_sums.push_back(~next_sum);
                    packet_sum = '0;
                end else begin
                    packet_sum = next_sum;
                end
            end
        end
        pending = expected_sums.size();
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Checksum engine testbench
// Drives directed corner items, then random IPv4/IPv6 packets with payload
// chunks and some noise, under three flow-control mixes; the checker does
// all prediction and comparison.
// ----------------------------------------------------------------------------
module tb;
    import ichk_pkg::*;

    localparam int ITEM_TARGET = 550;

    typedef struct packed {
        logic [3:0]  pad;
        logic [3:0]  byte_count;
        logic [63:0] payload;
        logic [31:0] length;
        logic [7:0]  protocol;
        logic [63:0] dst_low;
        logic [63:0] dst_high;
        logic [63:0] src_low;
        logic [63:0] src_high;
    } item_fields_t;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic [FUNC_W-1:0]      s_tuser;
    logic                   s_tlast;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tvalid;
    logic                   m_tready;

    int fail_count;
    int pending;
    int items_seen;
    int sums_seen;
    int items_sent;
    int src_idle_pct;
    int sink_stall_pct;

    internet_checksum_pseudo_header_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    checksum_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .m_tdata    (m_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .fail_count (fail_count),
        .pending    (pending),
        .items_seen (items_seen),
        .sums_seen  (sums_seen)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Stall the checksum side at random
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Hard stop
    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic item_fields_t rand_fields();
        item_fields_t f;
        f.pad        = '0;
        f.byte_count = 4'($urandom_range(15));
        f.payload    = rand64();
        f.length     = $urandom();
        f.protocol   = 8'($urandom_range(255));
        f.dst_low    = rand64();
        f.dst_high   = rand64();
        f.src_low    = rand64();
        f.src_high   = rand64();
        return f;
    endfunction

    // Pseudo-header with mostly clean unused bits and common protocols
    function automatic item_fields_t header_fields(input ichk_func_t kind);
        item_fields_t f;
        f = rand_fields();
        if (kind == FUNC_IPV4 && $urandom_range(3) != 0) begin
            f.src_high        = '0;
            f.dst_high        = '0;
            f.src_low[63:32]  = '0;
            f.dst_low[63:32]  = '0;
            f.length[31:16]   = '0;
        end
        case ($urandom_range(3))
            0: f.protocol = 8'h06;
            1: f.protocol = 8'h11;
            default: ;
        endcase
        return f;
    endfunction

    // Offer one transaction, idling first at the current rate
    task automatic send_item(input ichk_func_t kind, input item_fields_t f, input logic ends);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= f;
        s_tuser  <= kind;
        s_tlast  <= ends;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic set_phase();
        if (items_sent < ITEM_TARGET / 3) begin
            src_idle_pct   = 22;
            sink_stall_pct = 52;
        end else if (items_sent < 2 * ITEM_TARGET / 3) begin
            src_idle_pct   = 52;
            sink_stall_pct = 22;
        end else begin
            src_idle_pct   = 0;
            sink_stall_pct = 0;
        end
    endtask

    initial begin
        item_fields_t f;
        ichk_func_t   kind;
        int           n;

        aresetn        = 1'b0;
        s_tdata        = '0;
        s_tuser        = FUNC_PAYLOAD;
        s_tlast        = 1'b0;
        s_tvalid       = 1'b0;
        m_tready       = 1'b0;
        items_sent     = 0;
        src_idle_pct   = 22;
        sink_stall_pct = 52;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // IPv4 header with every unused bit set, then every byte count from 0 to 8
        f = '1;
        f.pad = '0;
        f.protocol = 8'h06;
        send_item(FUNC_IPV4, f, 1'b0);
        for (int c = 0; c <= 8; c++) begin
            f = rand_fields();
            f.byte_count = 4'(c);
            send_item(FUNC_PAYLOAD, f, 1'b0);
        end
        // counts past the chunk size, all-ones payload
        f = '1;
        f.pad = '0;
        f.byte_count = 4'd9;
        send_item(FUNC_PAYLOAD, f, 1'b0);
        f.byte_count = 4'd15;
        send_item(FUNC_PAYLOAD, f, 1'b0);
        // odd final byte closes the packet
        f = rand_fields();
        f.byte_count = 4'd1;
        send_item(FUNC_PAYLOAD, f, 1'b1);

        // IPv6 header, all ones, then a three-byte tail
        f = '1;
        f.pad = '0;
        f.protocol = 8'h11;
        send_item(FUNC_IPV6, f, 1'b0);
        f = rand_fields();
        f.byte_count = 4'd3;
        send_item(FUNC_PAYLOAD, f, 1'b1);

        // unknown kind: adds nothing, still ends a packet
        send_item(FUNC_NONE, rand_fields(), 1'b0);
        send_item(FUNC_NONE, rand_fields(), 1'b1);

        // all-zero payload and all-zero IPv4 header as single-item packets
        f = '0;
        f.byte_count = 4'd8;
        send_item(FUNC_PAYLOAD, f, 1'b1);
        send_item(FUNC_IPV4, '0, 1'b1);

        // random packets, with some noise mixed in
        while (items_sent < ITEM_TARGET) begin
            set_phase();
            if ($urandom_range(99) < 80) begin
                kind = ($urandom_range(1) == 0) ? FUNC_IPV4 : FUNC_IPV6;
                send_item(kind, header_fields(kind), 1'b0);
                n = ($urandom_range(9) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 5);
                for (int k = 0; k < n; k++) begin
                    f = rand_fields();
                    f.byte_count = (k == n - 1) ? 4'($urandom_range(1, 8)) : 4'd8;
                    if ($urandom_range(19) == 0)
                        f.byte_count = 4'($urandom_range(15));
                    send_item(FUNC_PAYLOAD, f, k == n - 1);
                end
            end else begin
                kind = ichk_func_t'($urandom_range(3));
                send_item(kind, rand_fields(), 1'($urandom_range(1)));
            end
        end
        // close any open packet
        send_item(FUNC_NONE, rand_fields(), 1'b1);
        s_tvalid <= 1'b0;

        // drain outstanding checksums, then watch for strays
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);

        $display("Sent %0d items (payload, IPv4, IPv6, unknown kinds) and checked %0d checksums",
                 items_seen, sums_seen);
        $display("under sender idling, receiver stalls, and full-rate streaming.");
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
